/* hdl/ffc_pkg.sv */
// ffc_pkg: frame layout constants, error codes, result type and crc byte update
`timescale 1ns / 1ps

package ffc_pkg;

    localparam logic [7:0]  START_MARK  = 8'h7b;
    localparam logic [7:0]  END_MARK    = 8'h7d;
    localparam logic [15:0] CRC_POLY    = 16'h8408;

    localparam logic [5:0]  POS_START   = 6'd0;
    localparam logic [5:0]  POS_TYPE    = 6'd1;
    localparam logic [5:0]  POS_SEQ     = 6'd2;
    localparam logic [5:0]  POS_LEN     = 6'd3;
    localparam logic [5:0]  POS_PAYLOAD = 6'd4;
    localparam logic [5:0]  POS_CRC_LO  = 6'd61;
    localparam logic [5:0]  POS_CRC_HI  = 6'd62;
    localparam logic [5:0]  POS_END     = 6'd63;
    localparam logic [7:0]  PAYLOAD_MAX = 8'd57;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_START  = 3'd1,
        ERR_END    = 3'd2,
        ERR_LENGTH = 3'd3,
        ERR_CRC    = 3'd4
    } ffc_err_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic       frame_ok;
        ffc_err_t   error_code;
        logic [7:0] type_res;
        logic [7:0] sequence_res;
        logic [7:0] length_res;
    } ffc_result_t;

    // reflected crc-16, one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/ffc_if.sv */
// ffc_if: valid/ready channels for the raw byte input and the result output
`timescale 1ns / 1ps

interface ffc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ffc_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       frame_ok;
    logic [2:0] error_code;
    logic [7:0] type_res;
    logic [7:0] sequence_res;
    logic [7:0] length_res;

    modport source (output valid, output kind, output payload_byte, output payload_index,
                    output frame_ok, output error_code, output type_res,
                    output sequence_res, output length_res, input ready);
    modport sink   (input valid, input kind, input payload_byte, input payload_index,
                    input frame_ok, input error_code, input type_res,
                    input sequence_res, input length_res, output ready);
endinterface

/* hdl/ffc_frame_engine.sv */
// ffc_frame_engine: frame position, crc and held header state, result decode per byte
`timescale 1ns / 1ps

module ffc_frame_engine
    import ffc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    output logic        has_result,
    output ffc_result_t result
);

    logic [5:0]  pos_reg,      pos_next;
    logic [15:0] crc_reg,      crc_next;
    logic        start_ok_reg, start_ok_next;
    logic [7:0]  type_reg,     type_next;
    logic [7:0]  seq_reg,      seq_next;
    logic [7:0]  len_reg,      len_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;
    logic [5:0]  idx;
    ffc_err_t    err;

    assign idx = pos_reg - POS_PAYLOAD;

    always_comb
    begin
        if (!start_ok_reg)
        begin
            err = ERR_START;
        end
        else if (data_byte != END_MARK)
        begin
            err = ERR_END;
        end
        else if (len_reg > PAYLOAD_MAX)
        begin
            err = ERR_LENGTH;
        end
        else if (crc_reg != 16'h0000)
        begin
            err = ERR_CRC;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg + 6'd1;
        crc_next      = crc_reg;
        start_ok_next = start_ok_reg;
        type_next     = type_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        crc_lo_next   = crc_lo_reg;
        has_result    = 1'b0;

        result              = '0;
        result.error_code   = ERR_NONE;
        result.type_res     = type_reg;
        result.sequence_res = seq_reg;
        result.length_res   = len_reg;

        if (pos_reg == POS_START)
        begin
            start_ok_next = (data_byte == START_MARK);
            crc_next      = 16'h0000;
        end
        else if (pos_reg < POS_CRC_LO)
        begin
            crc_next = crc_byte(crc_reg, data_byte);
            if (pos_reg == POS_TYPE)
            begin
                type_next = data_byte;
            end
            else if (pos_reg == POS_SEQ)
            begin
                seq_next = data_byte;
            end
            else if (pos_reg == POS_LEN)
            begin
                len_next = data_byte;
            end
            else if ({2'b00, idx} < len_reg)
            begin
                has_result           = 1'b1;
                result.kind          = KIND_PAYLOAD;
                result.payload_byte  = data_byte;
                result.payload_index = idx;
            end
        end
        else if (pos_reg == POS_CRC_LO)
        begin
            crc_lo_next = data_byte;
        end
        else if (pos_reg == POS_CRC_HI)
        begin
            crc_next = crc_reg ^ {data_byte, crc_lo_reg};
        end
        else
        begin
            has_result        = 1'b1;
            result.kind       = KIND_STATUS;
            result.frame_ok   = (err == ERR_NONE);
            result.error_code = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            start_ok_reg <= 1'b0;
            type_reg     <= '0;
            seq_reg      <= '0;
            len_reg      <= '0;
            crc_lo_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            start_ok_reg <= start_ok_next;
            type_reg     <= type_next;
            seq_reg      <= seq_next;
            len_reg      <= len_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

    // position moves by exactly one per processed byte
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> pos_reg == $past(pos_reg) + 6'd1)
        else $error("frame position did not advance by one");

    // status beats come only from the end mark position
    a_status_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && result.kind == KIND_STATUS) |-> pos_reg == POS_END)
        else $error("status beat outside end position");

    // payload beats carry an index below both the limit and the length byte
    a_payload_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && result.kind == KIND_PAYLOAD) |->
        ({2'b00, result.payload_index} < PAYLOAD_MAX &&
         {2'b00, result.payload_index} < len_reg))
        else $error("payload index out of range");

    // frame_ok and a zero error code go together on status beats
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && result.kind == KIND_STATUS) |->
        (result.frame_ok == (result.error_code == ERR_NONE)))
        else $error("frame_ok disagrees with error code");

endmodule

/* hdl/fixed_frame_checker_crc16_core.sv */
// fixed_frame_checker_crc16_core: top level of the fixed 64-byte frame checker
`timescale 1ns / 1ps

// Checks a stream of fixed 64-byte frames, one byte per input beat, with the byte
// position counted from reset and wrapping from 63 to 0 so frames run back to back.
// Byte 0 must be 0x7b, bytes 1..3 carry type, sequence and payload length, bytes
// 4..60 are payload, 61..62 the crc (low byte first) and byte 63 must be 0x7d. A
// reflected crc-16 (poly 0x8408, init 0, no final xor) covers bytes 1..60. Each
// payload byte whose index is below the length byte gives one payload beat as it
// passes; byte 63 gives one status beat whose error code names the first failing
// check in the order start, end, length over 57, crc. The block takes one byte per
// cycle while not stalled: a byte goes into an input register, from which the frame
// engine updates its state with an unrolled eight-bit crc step and writes any result
// beat into the output register. A full output register that is not taken only
// stalls the input when the byte waiting in the input register would itself give a
// result beat.
module fixed_frame_checker_crc16_core
    import ffc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ffc_in_if.sink    in_ch,
    ffc_out_if.source out_ch
);

    // input register
    logic        in_vld_reg,  in_vld_next;
    logic [7:0]  in_byte_reg;

    // output register
    logic        out_vld_reg, out_vld_next;
    ffc_result_t out_res_reg;

    // engine handshake
    logic        advance;
    logic        has_result;
    ffc_result_t result;

    ffc_frame_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .has_result (has_result),
        .result     (result)
    );

    // process the held byte unless its result beat has nowhere to go
    assign advance     = in_vld_reg && (!has_result || !out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ch.valid && in_ch.ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance && has_result)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.data_byte;
        end
        if (advance && has_result)
        begin
            out_res_reg <= result;
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.kind          = out_res_reg.kind;
    assign out_ch.payload_byte  = out_res_reg.payload_byte;
    assign out_ch.payload_index = out_res_reg.payload_index;
    assign out_ch.frame_ok      = out_res_reg.frame_ok;
    assign out_ch.error_code    = out_res_reg.error_code;
    assign out_ch.type_res      = out_res_reg.type_res;
    assign out_ch.sequence_res  = out_res_reg.sequence_res;
    assign out_ch.length_res    = out_res_reg.length_res;

    // a result beat is never dropped: a pending beat is either taken or kept
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ch.ready) |-> !(advance && has_result))
        else $error("pending result beat overwritten");

    // input stalls only behind a result-bearing byte and a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_vld_reg && has_result && out_vld_reg && !out_ch.ready))
        else $error("input stalled without cause");

    // a held byte that is not processed stays held
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("held input byte lost");

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for the fixed 64-byte frame checker with crc-16
`timescale 1ns / 1ps

// Drives 64-byte frames into the checker one byte per input beat and checks
// every result beat against a local frame predictor. The predictor tracks the byte
// position from reset, the reflected crc-16 over bytes 1..60, the held header bytes
// and the received crc. It queues the payload beat or the status beat that each
// accepted byte should give. A monitor pops that queue on each accepted output beat
// and compares field by field. Directed frames cover the header extremes, a full
// payload, every error code and the order in which the checks take priority.
// Random traffic follows, mostly well-formed with random content and the rest broken
// or pure noise. Source gaps and sink stalls vary by phase.
module tb;
    import ffc_pkg::*;

    localparam int FRAME_BYTES = 64;

    logic clk;
    logic rst_n;

    ffc_in_if  in_ch ();
    ffc_out_if out_ch ();

    fixed_frame_checker_crc16_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state, a copy of what the checker should hold
    logic [5:0]  frame_pos;
    logic [15:0] crc_acc;
    logic        start_good;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_len;
    logic [7:0]  crc_low_rx;

    // result beats predicted but not yet seen on the output
    ffc_result_t frame_results_due[$];
    ffc_result_t due_beat;

    // the frame being built for the next send
    logic [7:0] frame_buf [FRAME_BYTES];

    // next byte of frame_buf for random traffic
    int send_idx;

    // idle rates of the current phase, in percent
    int src_idle_pct;
    int sink_stall_pct;
    int fail_count;

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("fixed_frame_checker_crc16_core: mismatch");
        $finish;
    end

    // reflected crc-16, one data bit at a time, lsb first
    function automatic logic [15:0] kermit_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ b[k])
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    // advance the predictor by one accepted byte and queue what it should give
    task automatic predict_frame_byte(input logic [7:0] b);
        ffc_result_t r;
        ffc_err_t    err;
        logic [5:0]  idx;
        logic        emit;
        r    = '0;
        emit = 1'b0;
        if (frame_pos == POS_START)
        begin
            start_good = (b == START_MARK);
            crc_acc    = 16'h0000;
        end
        else if (frame_pos < POS_CRC_LO)
        begin
            crc_acc = kermit_update(crc_acc, b);
            case (frame_pos)
                POS_TYPE: frame_type = b;
                POS_SEQ:  frame_seq  = b;
                POS_LEN:  frame_len  = b;
                default:
                begin
                    // payload beat only while the index is inside the length byte
                    idx = frame_pos - POS_PAYLOAD;
                    if ({2'b00, idx} < frame_len)
                    begin
                        r.kind          = KIND_PAYLOAD;
                        r.payload_byte  = b;
                        r.payload_index = idx;
                        emit            = 1'b1;
                    end
                end
            endcase
        end
        else if (frame_pos == POS_CRC_LO)
        begin
            crc_low_rx = b;
        end
        else if (frame_pos == POS_CRC_HI)
        begin
            // folding in the received crc leaves zero on a match
            crc_acc = crc_acc ^ {b, crc_low_rx};
        end
        else
        begin
            // first failing check wins: start, end, length, crc
            if (!start_good)
                err = ERR_START;
            else if (b != END_MARK)
                err = ERR_END;
            else if (frame_len > PAYLOAD_MAX)
                err = ERR_LENGTH;
            else if (crc_acc != 16'h0000)
                err = ERR_CRC;
            else
                err = ERR_NONE;
            r.kind       = KIND_STATUS;
            r.frame_ok   = (err == ERR_NONE);
            r.error_code = err;
            emit         = 1'b1;
        end
        if (emit)
        begin
            r.type_res     = frame_type;
            r.sequence_res = frame_seq;
            r.length_res   = frame_len;
            frame_results_due.push_back(r);
        end
        frame_pos = frame_pos + 6'd1;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // output monitor: one compare per accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $error("result beat with nothing expected, kind %0h", out_ch.kind);
                fail_count++;
            end
            else
            begin
                due_beat = frame_results_due.pop_front();
                check_field("kind", due_beat.kind, out_ch.kind);
                check_field("payload_byte", due_beat.payload_byte, out_ch.payload_byte);
                check_field("payload_index", due_beat.payload_index, out_ch.payload_index);
                check_field("frame_ok", due_beat.frame_ok, out_ch.frame_ok);
                check_field("error_code", due_beat.error_code, out_ch.error_code);
                check_field("type_res", due_beat.type_res, out_ch.type_res);
                check_field("sequence_res", due_beat.sequence_res, out_ch.sequence_res);
                check_field("length_res", due_beat.length_res, out_ch.length_res);
            end
        end
    end

    // sink side: random stalls at the phase rate
    always @(negedge clk)
    begin
        if (sink_stall_pct == 0)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // one input beat; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b);
        // source gaps, with junk on the data lines
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'($urandom);
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_frame_byte(b);
        @(negedge clk);
    endtask

    // hold the source off until every predicted beat has come out
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // well-formed frame; fill below zero means random payload
    task automatic make_frame(input logic [7:0] ftype, input logic [7:0] fseq,
                              input logic [7:0] flen, input int fill);
        logic [15:0] c;
        c = 16'h0000;
        frame_buf[POS_START] = START_MARK;
        frame_buf[POS_TYPE]  = ftype;
        frame_buf[POS_SEQ]   = fseq;
        frame_buf[POS_LEN]   = flen;
        for (int i = POS_PAYLOAD; i < POS_CRC_LO; i++)
            frame_buf[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
        for (int i = POS_TYPE; i < POS_CRC_LO; i++)
            c = kermit_update(c, frame_buf[i]);
        frame_buf[POS_CRC_LO] = c[7:0];
        frame_buf[POS_CRC_HI] = c[15:8];
        frame_buf[POS_END]    = END_MARK;
    endtask

    // pause_at names a byte before which the source waits for all results, -1 for none
    task automatic send_frame(input int pause_at);
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (i == pause_at)
                wait_for_results();
            send_byte(frame_buf[i]);
        end
    endtask

    // clean frame at the edges of the header range with a full payload
    task automatic test_good_frames();
        make_frame(8'hff, 8'h00, 8'd57, 8'hff);
        send_frame(30);
        wait_for_results();
    endtask

    // several failures at once, only the first in check order counts
    task automatic test_error_order();
        // bad start beats bad end, long length and bad crc
        make_frame(8'h5a, 8'h01, 8'd200, -1);
        frame_buf[POS_START]  = 8'h00;
        frame_buf[POS_END]    = 8'hff;
        frame_buf[POS_CRC_HI] = ~frame_buf[POS_CRC_HI];
        send_frame(-1);
        // bad end beats longest length and bad crc
        make_frame(8'ha5, 8'h02, 8'd255, -1);
        frame_buf[POS_END]    = 8'h7c;
        frame_buf[POS_CRC_LO] = ~frame_buf[POS_CRC_LO];
        send_frame(-1);
        // length just over the limit beats bad crc
        make_frame(8'h3c, 8'h03, 8'd58, -1);
        frame_buf[POS_CRC_LO] = frame_buf[POS_CRC_LO] ^ 8'h01;
        send_frame(-1);
        wait_for_results();
    endtask

    // crc mismatch from damaged payload
    task automatic test_crc_errors();
        // payload beats still come out before the failing status
        make_frame(8'h33, 8'h55, 8'd10, -1);
        frame_buf[POS_PAYLOAD + 5] = frame_buf[POS_PAYLOAD + 5] ^ 8'h04;
        send_frame(-1);
        wait_for_results();
    endtask

    // mostly clean frames with random content, the rest broken or noise;
    // a phase sends count bytes and may end mid-frame
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int count);
        int sel;
        int pos;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int n = 0; n < count; n++)
        begin
            if (send_idx == 0)
            begin
                sel = $urandom_range(99);
                make_frame(8'($urandom), 8'($urandom), 8'($urandom_range(0, 57)), -1);
                if (sel < 60)
                begin
                    // clean frame
                end
                else if (sel < 72)
                begin
                    // single damaged byte anywhere from the type byte through the crc bytes
                    pos = $urandom_range(POS_TYPE, POS_CRC_HI);
                    frame_buf[pos] = frame_buf[pos] ^ (8'd1 << $urandom_range(7));
                end
                else if (sel < 80)
                    make_frame(8'($urandom), 8'($urandom), 8'($urandom_range(58, 255)), -1);
                else if (sel < 87)
                    frame_buf[POS_END] = 8'($urandom);
                else if (sel < 93)
                    frame_buf[POS_START] = 8'($urandom);
                else
                begin
                    // pure noise
                    for (int i = 0; i < FRAME_BYTES; i++)
                        frame_buf[i] = 8'($urandom);
                end
            end
            send_byte(frame_buf[send_idx]);
            send_idx = (send_idx == FRAME_BYTES - 1) ? 0 : send_idx + 1;
        end
        // source holds off mid-frame until everything so far has drained
        wait_for_results();
    endtask

    initial
    begin
        // known values on every input from time zero
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready    = 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        fail_count      = 0;
        send_idx        = 0;
        frame_pos       = 6'd0;
        crc_acc         = 16'h0000;
        start_good      = 1'b0;
        frame_type      = 8'h00;
        frame_seq       = 8'h00;
        frame_len       = 8'h00;
        crc_low_rx      = 8'h00;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_good_frames();
        test_error_order();
        test_crc_errors();
        // no idling, mostly idle source, stalling sink, light idling on both sides
        test_random_traffic(0, 0, 16);
        test_random_traffic(71, 0, 16);
        test_random_traffic(0, 71, 16);
        test_random_traffic(10, 10, 16);

        // everything predicted has come out; give any stray beat time to show
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("fixed_frame_checker_crc16_core: match");
        else
            $display("fixed_frame_checker_crc16_core: mismatch");
        $finish;
    end

endmodule
